FILE: rtl/trace_response_convolver_assert.svh
// Assertion macros shared by the trace_response_convolver RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef TRACE_RESPONSE_CONVOLVER_ASSERT_SVH
`define TRACE_RESPONSE_CONVOLVER_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is held
`define TRC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check, active through reset as well
`define TRC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRC_ASSERT(label, clk, rst_n, prop, msg)
`define TRC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: rtl/trc_pkg.sv
// Shared constants and controller/datapath interface types for the convolver.
// No dependencies.
package trc_pkg;

    // Parameter defaults
    localparam int TRC_TAPS_DEF        = 512;
    localparam int TRC_SAMPLE_BITS_DEF = 16;

    // Fixed field widths
    localparam int COEF_W = 16;
    localparam int IDX_W  = 9;
    localparam int VAL_W  = 41;
    localparam int POS_W  = 9;

    // Result transaction packing
    localparam int OUT_FIELDS_W = VAL_W + POS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Item kinds carried in tuser
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic clr_wr;      // write zero to coefficient at tap index
        logic load_wr;     // write loaded coefficient
        logic sample_wr;   // store sample, update trace count, clear accumulator
        logic issue;       // read history and coefficient for one tap
        logic issue_last;  // final tap of this sample
        logic out_load;    // move accumulator into the output register
    } trc_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic acc_done;    // last product has been accumulated
        logic out_full;    // output register holds an untaken result
    } trc_sts_t;

endpackage

FILE: rtl/trc_datapath.sv
// Convolver datapath: coefficient and history memories, MAC pipeline, output register.
// Depends on trc_pkg; driven by trc_controller commands.
module trc_datapath
    import trc_pkg::*;
#(
    parameter int TAPS        = TRC_TAPS_DEF,
    parameter int SAMPLE_BITS = TRC_SAMPLE_BITS_DEF,
    localparam int AW         = $clog2(TAPS),
    localparam int CW         = $clog2(TAPS + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  trc_cmd_t               cmd,
    input  logic [AW-1:0]          tap_idx,
    input  logic [IDX_W-1:0]       coef_index,
    input  logic [COEF_W-1:0]      coef_value,
    input  logic [SAMPLE_BITS-1:0] sample_value,
    input  logic                   trace_start,
    output trc_sts_t               sts,
    output logic [CW-1:0]          count,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int PROD_W = SAMPLE_BITS + COEF_W;

    // Memories
    logic [COEF_W-1:0]      coef_mem [TAPS];
    logic [SAMPLE_BITS-1:0] hist_mem [TAPS];
    logic [COEF_W-1:0]      coef_rd_reg;
    logic [SAMPLE_BITS-1:0] hist_rd_reg;

    // Control state
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          s1_vld_reg, s1_last_reg;
    logic          s2_vld_reg, s2_last_reg;
    logic          done_reg;
    logic          out_vld_reg, out_vld_next;

    // Payload
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [VAL_W-1:0]  acc_reg, acc_next;
    logic [OUT_TDATA_W-1:0]   out_data_reg;

    logic [AW+IDX_W-1:0] idx_wide;
    logic [AW-1:0]       load_addr;
    logic                coef_we;
    logic [AW-1:0]       coef_waddr;
    logic [COEF_W-1:0]   coef_wdata;
    logic [CW-1:0]       cnt_base;
    logic [CW-1:0]       cnt_m1;
    logic [CW+POS_W-1:0] pos_wide;
    logic [POS_W-1:0]    trace_pos;

    // Coefficient write port: clearing pass or load
    assign idx_wide   = {{AW{1'b0}}, coef_index};
    assign load_addr  = idx_wide[AW-1:0];
    assign coef_we    = cmd.clr_wr | (cmd.load_wr && (32'(coef_index) < 32'(TAPS)));
    assign coef_waddr = cmd.clr_wr ? tap_idx : load_addr;
    assign coef_wdata = cmd.clr_wr ? '0 : coef_value;

    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        coef_rd_reg <= coef_mem[tap_idx];
    end

    // History write at the write pointer, read walking backwards
    always_ff @(posedge aclk) begin
        if (cmd.sample_wr) begin
            hist_mem[wptr_reg] <= sample_value;
        end
        hist_rd_reg <= hist_mem[rptr_reg];
    end

    // Pointer and trace count update
    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        cnt_base  = trace_start ? '0 : cnt_reg;
        if (cmd.sample_wr) begin
            wptr_next = (wptr_reg == AW'(TAPS - 1)) ? '0 : wptr_reg + 1'b1;
            rptr_next = wptr_reg;
            cnt_next  = (cnt_base < CW'(TAPS)) ? cnt_base + 1'b1 : cnt_base;
        end else if (cmd.issue) begin
            rptr_next = (rptr_reg == '0) ? AW'(TAPS - 1) : rptr_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // MAC pipeline valid and last tags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s2_last_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            s1_vld_reg  <= cmd.issue;
            s1_last_reg <= cmd.issue & cmd.issue_last;
            s2_vld_reg  <= s1_vld_reg;
            s2_last_reg <= s1_last_reg;
            done_reg    <= s2_last_reg;
        end
    end

    // Multiply, then accumulate with wrap at the result width
    always_comb begin
        acc_next = acc_reg;
        if (cmd.sample_wr) begin
            acc_next = '0;
        end else if (s2_vld_reg) begin
            acc_next = acc_reg + VAL_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= $signed(hist_rd_reg) * $signed(coef_rd_reg);
        acc_reg  <= acc_next;
    end

    // Position within trace, saturating at the last tap
    assign cnt_m1    = cnt_reg - 1'b1;
    assign pos_wide  = {{POS_W{1'b0}}, cnt_m1};
    assign trace_pos = pos_wide[POS_W-1:0];

    // Output register
    always_comb begin
        out_vld_next = out_vld_reg;
        if (cmd.out_load) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= OUT_TDATA_W'({trace_pos, acc_reg});
        end
    end

    assign sts.acc_done = done_reg;
    assign sts.out_full = out_vld_reg;
    assign count        = cnt_reg;
    assign m_tvalid     = out_vld_reg;
    assign m_tdata      = out_data_reg;

endmodule

FILE: rtl/trc_controller.sv
// Convolver controller: clearing pass, input acceptance, tap sequencing, result hand-off.
// Depends on trc_pkg and the assertion macro header.
`include "trace_response_convolver_assert.svh"
module trc_controller
    import trc_pkg::*;
#(
    parameter int TAPS = TRC_TAPS_DEF,
    localparam int AW  = $clog2(TAPS),
    localparam int CW  = $clog2(TAPS + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          kind,
    input  logic          m_tready,
    input  trc_sts_t      sts,
    input  logic [CW-1:0] count,
    output trc_cmd_t      cmd,
    output logic [AW-1:0] tap_idx
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] tap_reg, tap_next;
    logic          accept;
    logic          tap_last;

    assign accept   = s_tvalid & s_tready;
    assign tap_last = ((CW'(tap_reg) + 1'b1) == count);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        tap_next   = tap_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (tap_reg == AW'(TAPS - 1)) begin
                    tap_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    if (kind == KIND_SAMPLE) begin
                        cmd.sample_wr = 1'b1;
                        tap_next      = '0;
                        state_next    = ST_RUN;
                    end else begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                cmd.issue      = 1'b1;
                cmd.issue_last = tap_last;
                if (tap_last) begin
                    tap_next   = '0;
                    state_next = ST_WAIT;
                end else begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            ST_WAIT: begin
                if (sts.acc_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!sts.out_full || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                tap_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            tap_reg   <= '0;
        end else begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

    assign tap_idx = tap_reg;

    `TRC_ASSERT(a_done_in_wait, aclk, aresetn, sts.acc_done |-> (state_reg == ST_WAIT), "accumulator finished outside wait state")
    `TRC_ASSERT(a_last_to_wait, aclk, aresetn, cmd.issue_last |=> (state_reg == ST_WAIT), "final tap not followed by wait state")
    `TRC_ASSERT(a_tap_in_range, aclk, aresetn, (state_reg == ST_RUN) |-> (CW'(tap_reg) < count), "tap index beyond samples in trace")
    `TRC_ASSERT(a_no_overwrite, aclk, aresetn, cmd.out_load |-> (!sts.out_full || m_tready), "result register overwritten before it was taken")

endmodule

FILE: rtl/trace_response_convolver.sv
// Top level of the trace response convolver: stream ports, field unpacking, controller and datapath.
// Depends on trc_pkg, trc_controller and trc_datapath.
//
//  channel | direction | tdata (low bit up)                          | tuser (low bit up)
//  s_      | in        | coef_index, coef_value, sample_value, zeros | kind, trace_start
//  m_      | out       | filtered_value, trace_position, zeros       | -
//
// A sample is convolved over N taps, N being the samples counted in its trace
// (1 to TAPS): one shared multiply-accumulate walks the taps one per cycle
// through one read port on each of the two memories. After reset the block
// sweeps the coefficient memory to zero with s_tready low. A result stalled on
// m_tready holds the next sample at its hand-off, and no input, loads included,
// is taken meanwhile.
module trace_response_convolver
    import trc_pkg::*;
#(
    parameter int TAPS        = TRC_TAPS_DEF,
    parameter int SAMPLE_BITS = TRC_SAMPLE_BITS_DEF,
    localparam int IN_FIELDS_W = IDX_W + COEF_W + SAMPLE_BITS,
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // coef_index, coef_value, sample_value, zero fill
    input  logic [1:0]             s_tuser,   // kind, trace_start
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // filtered_value, trace_position, zero fill
);

    localparam int AW = $clog2(TAPS);
    localparam int CW = $clog2(TAPS + 1);

    logic                   kind;
    logic                   trace_start;
    logic [IDX_W-1:0]       coef_index;
    logic [COEF_W-1:0]      coef_value;
    logic [SAMPLE_BITS-1:0] sample_value;
    trc_cmd_t               cmd;
    trc_sts_t               sts;
    logic [AW-1:0]          tap_idx;
    logic [CW-1:0]          count;

    // Unpack the input transaction
    assign kind         = s_tuser[0];
    assign trace_start  = s_tuser[1];
    assign coef_index   = s_tdata[IDX_W-1:0];
    assign coef_value   = s_tdata[IDX_W+COEF_W-1:IDX_W];
    assign sample_value = s_tdata[IN_FIELDS_W-1:IDX_W+COEF_W];

    trc_controller #(
        .TAPS (TAPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (kind),
        .m_tready (m_tready),
        .sts      (sts),
        .count    (count),
        .cmd      (cmd),
        .tap_idx  (tap_idx)
    );

    trc_datapath #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .tap_idx      (tap_idx),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .sample_value (sample_value),
        .trace_start  (trace_start),
        .sts          (sts),
        .count        (count),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

FILE: tb/tb_trace_response_convolver.sv
// Self-checking testbench for trace_response_convolver: directed table, then random traces.
// Depends on trc_pkg and the convolver RTL; typed rows give a result, else its own convolution.
module tb_trace_response_convolver;
    import trc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPS         = TRC_TAPS_DEF;
    localparam int SAMPLE_BITS  = TRC_SAMPLE_BITS_DEF;
    localparam int IN_FIELDS_W  = IDX_W + COEF_W + SAMPLE_BITS;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 1150;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 3000;
    localparam int LONG_TRACE   = 12;
    localparam int LIMIT_CYCLES = 3000000;

    typedef struct {
        logic                    kind;
        logic [IDX_W-1:0]        idx;
        logic signed [COEF_W-1:0] coef;
        logic signed [SAMPLE_BITS-1:0] samp;
        logic                    start;
    } trace_item_t;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        pos;
    } conv_result_t;

    typedef struct {
        trace_item_t it;
        bit          typed;
        longint      val;
        int          pos;
    } directed_row_t;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [1:0]             s_tuser  = '0;   // kind, trace_start
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // filtered_value, trace_position, zero fill

    // Predictor state
    logic signed [COEF_W-1:0]      coef_tab [TAPS];
    logic signed [SAMPLE_BITS-1:0] hist     [TAPS];
    logic [IDX_W-1:0]              wr_ptr;
    int                            trace_len;

    conv_result_t  pending_sums[$];
    directed_row_t directed[$];
    int            sent_count   = 0;
    int            error_count  = 0;
    int            cycle_count  = 0;
    bit            sender_quiet = 1'b0;

    trace_response_convolver dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Advance the predicted convolution by one transaction; returns 1 when a result is due
    function automatic bit convolve_step(input trace_item_t it, output conv_result_t r);
        longint           acc;
        logic [IDX_W-1:0] p;
        r.value = '0;
        r.pos   = '0;
        if (it.kind == KIND_LOAD) begin
            if (it.idx < TAPS) coef_tab[it.idx] = it.coef;
            return 1'b0;
        end
        if (it.start) trace_len = 0;
        hist[wr_ptr] = it.samp;
        if (trace_len < TAPS) trace_len++;
        acc = 0;
        p   = wr_ptr;
        for (int k = 0; k < trace_len; k++) begin
            acc += longint'(hist[p]) * longint'(coef_tab[k]);
            p = p - 1'b1;   // 9-bit pointer wraps at the table depth
        end
        wr_ptr  = wr_ptr + 1'b1;
        r.value = acc[VAL_W-1:0];
        r.pos   = POS_W'(trace_len - 1);
        return 1'b1;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (sender_quiet) return 0;
        if (r < 5) return $urandom_range(20, 60);
        if (r < 40) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Bias towards the extremes of a 16-bit word
    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic trace_item_t rand_item(input logic kind);
        trace_item_t it;
        it.kind  = kind;
        it.idx   = IDX_W'($urandom_range(0, 511));
        it.coef  = rand_word();
        it.samp  = rand_word();
        it.start = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic log_mismatch(input string what, input conv_result_t want,
                                input conv_result_t got);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] %s: expected value %0d pos %0d, got value %0d pos %0d",
                     $realtime, what, want.value, want.pos, got.value, got.pos);
    endtask

    // Offer one transaction, hold it until taken, then predict its result
    task automatic send_item(input trace_item_t it, input bit typed, input longint tval,
                             input int tpos);
        int           gap;
        conv_result_t r;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, it.samp, it.coef, it.idx};
        s_tuser  <= {it.start, it.kind};
        do @(posedge aclk); while (!s_tready);
        sent_count++;
        if (convolve_step(it, r)) begin
            if (typed) begin
                r.value = tval[VAL_W-1:0];
                r.pos   = POS_W'(tpos);
            end
            pending_sums = {pending_sums, r};
        end
    endtask

    task automatic add_row(input logic kind, input int idx, input logic [15:0] coef,
                           input logic [15:0] samp, input logic start, input bit typed,
                           input longint val, input int pos);
        directed_row_t row;
        row.it.kind  = kind;
        row.it.idx   = IDX_W'(idx);
        row.it.coef  = coef;
        row.it.samp  = samp;
        row.it.start = start;
        row.typed    = typed;
        row.val      = val;
        row.pos      = pos;
        directed = {directed, row};
    endtask

    // Stimulus
    initial begin
        trace_item_t it;
        bit          long_tr;
        int          n_loads;
        int          len;
        int          tr_count;
        for (int i = 0; i < TAPS; i++) begin
            coef_tab[i] = '0;
            hist[i]     = '0;
        end
        wr_ptr    = '0;
        trace_len = 0;
        tr_count  = 0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // First sample after reset opens a trace even without its start bit
        add_row(KIND_SAMPLE, 0,   16'h0000, 16'h7FFF, 1'b0, 1, 0, 0);
        add_row(KIND_SAMPLE, 0,   16'h0000, 16'h8000, 1'b0, 1, 0, 1);
        add_row(KIND_LOAD,   0,   16'h7FFF, 16'h0000, 1'b0, 0, 0, 0);
        add_row(KIND_SAMPLE, 0,   16'h0000, 16'h8000, 1'b1, 1, -1073709056, 0);
        add_row(KIND_LOAD,   0,   16'h8000, 16'h0000, 1'b0, 0, 0, 0);
        add_row(KIND_SAMPLE, 0,   16'h0000, 16'h8000, 1'b1, 1, 1073741824, 0);
        add_row(KIND_LOAD,   1,   16'h8000, 16'h0000, 1'b0, 0, 0, 0);
        add_row(KIND_SAMPLE, 0,   16'h0000, 16'h8000, 1'b0, 1, 64'sd2147483648, 1);
        add_row(KIND_LOAD,   511, 16'h7FFF, 16'hFFFF, 1'b1, 0, 0, 0);
        add_row(KIND_LOAD,   511, 16'h8000, 16'h0000, 1'b0, 0, 0, 0);
        add_row(KIND_SAMPLE, 0,   16'h0000, 16'h7FFF, 1'b1, 1, -1073709056, 0);
        // Unused fields set on both kinds
        add_row(KIND_LOAD,   2,   16'h1234, 16'hFFFF, 1'b1, 0, 0, 0);
        add_row(KIND_SAMPLE, 511, 16'hFFFF, 16'h0000, 1'b0, 0, 0, 0);
        add_row(KIND_SAMPLE, 0,   16'h0000, 16'hFFFF, 1'b0, 0, 0, 0);
        add_row(KIND_LOAD,   0,   16'h0000, 16'h0000, 1'b0, 0, 0, 0);
        add_row(KIND_LOAD,   1,   16'h0000, 16'h0000, 1'b0, 0, 0, 0);
        add_row(KIND_SAMPLE, 0,   16'h0000, 16'h7FFF, 1'b1, 1, 0, 0);
        add_row(KIND_LOAD,   3,   16'hFFFF, 16'h0000, 1'b0, 0, 0, 0);
        add_row(KIND_SAMPLE, 0,   16'h0000, 16'h8000, 1'b0, 0, 0, 0);
        add_row(KIND_SAMPLE, 0,   16'h0000, 16'h7FFF, 1'b0, 0, 0, 0);
        add_row(KIND_SAMPLE, 0,   16'h0000, 16'h5A5A, 1'b0, 0, 0, 0);

        foreach (directed[i])
            send_item(directed[i].it, directed[i].typed, directed[i].val, directed[i].pos);

        // Random traces, each preceded by zero to five coefficient loads (48 before the long trace)
        while (sent_count < directed.size() + RANDOM_ITEMS) begin
            tr_count++;
            long_tr      = (tr_count == LONG_TRACE);
            sender_quiet = ($urandom_range(0, 3) == 0);
            n_loads      = long_tr ? 48 : $urandom_range(0, 5);
            for (int i = 0; i < n_loads; i++) begin
                it = rand_item(KIND_LOAD);
                if (!long_tr && $urandom_range(0, 3) != 0)
                    it.idx = IDX_W'($urandom_range(0, 31));
                if (long_tr && i == 0) it.idx = IDX_W'(TAPS - 1);
                send_item(it, 0, 0, 0);
            end
            if (long_tr) len = TAPS + 18;
            else if ($urandom_range(0, 7) == 0) len = $urandom_range(25, 70);
            else len = $urandom_range(1, 24);
            for (int j = 0; j < len; j++) begin
                // Stray load in the middle of a trace
                if (!long_tr && $urandom_range(0, 19) == 0)
                    send_item(rand_item(KIND_LOAD), 0, 0, 0);
                it = rand_item(KIND_SAMPLE);
                if (long_tr)
                    it.start = (j == 0);
                else if (j == 0)
                    it.start = ($urandom_range(0, 15) != 0);
                else
                    it.start = ($urandom_range(0, 63) == 0);
                send_item(it, 0, 0, 0);
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then allow the longest sample time before judging
        while (pending_sums.size() != 0) @(posedge aclk);
        repeat (TAPS + 16) @(posedge aclk);
        if (error_count == 0 && pending_sums.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Receiver: random stalls, one long hold-off to back the block up
    initial begin
        bit held;
        int run;
        int gap;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && sent_count >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++) @(posedge aclk);
            end else begin
                run = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
                m_tready <= 1'b1;
                repeat (run) @(posedge aclk);
                gap = $urandom_range(0, 99);
                gap = (gap < 5) ? $urandom_range(20, 80) :
                      (gap < 50) ? $urandom_range(1, 4) : 0;
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    // Result checker: compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        conv_result_t got;
        conv_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.value = m_tdata[VAL_W-1:0];
            got.pos   = m_tdata[VAL_W +: POS_W];
            if (pending_sums.size() == 0) begin
                want.value = '0;
                want.pos   = '0;
                log_mismatch("unexpected result", want, got);
            end else begin
                want = pending_sums.pop_front();
                if (got.value !== want.value || got.pos !== want.pos)
                    log_mismatch("mismatch", want, got);
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/trc_pkg.sv
rtl/trc_datapath.sv
rtl/trc_controller.sv
rtl/trace_response_convolver.sv
tb/tb_trace_response_convolver.sv
